/* rtl/uer_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Item layouts, event and outcome codes, controller commands and status.
// ----------------------------------------------------------------------------
package uer_pkg;

  // field widths
  localparam int STAMP_W = 32;
  localparam int RATE_W  = 27;
  localparam int LIMIT_W = 20;
  localparam int DIST_W  = 18;
  localparam int PULSE_W = 32;
  localparam int OUT_CNT_W = 32;
  localparam int CFG_IDX_W = 4;

  // multiplier and divider sizing
  localparam int MUL_B_W = 30;
  // ticks * 1e6 and pulse * distance reciprocal both stay below 2^52
  localparam int PROD_W  = 52;
  localparam int QUOT_W  = PULSE_W;
  localparam int DIST_SHIFT = 32;

  // arithmetic constants
  localparam logic [PULSE_W-1:0] MIN_PULSE_US = 32'd100;
  localparam logic [MUL_B_W-1:0] SOUND_NUM    = 30'd343;
  localparam logic [RATE_W-1:0]  SOUND_DEN    = 27'd2000;
  localparam logic [MUL_B_W-1:0] US_PER_S     = 30'd1000000;
  // 343 / 2000 scaled by 2^32 and rounded up, exact for pulses below 2^21
  localparam logic [MUL_B_W-1:0] DIST_RECIP   =
    MUL_B_W'(((64'(SOUND_NUM) << DIST_SHIFT) + 64'(SOUND_DEN) - 64'd1) / 64'(SOUND_DEN));

  // register reset values
  localparam logic [RATE_W-1:0]  RATE_RESET  = 27'd1000000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd30000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_LIMIT = 4'd1;

  // event kinds
  typedef enum logic [1:0] {
    REQ_ARM    = 2'd0,
    REQ_RISE   = 2'd1,
    REQ_FALL   = 2'd2,
    REQ_EXPIRE = 2'd3
  } req_kind_t;

  // measurement outcomes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [STAMP_W-1:0] stamp;
  } req_item_t;

  typedef struct packed {
    status_t              status;
    logic                 reading_valid;
    logic [DIST_W-1:0]    range_mm;
    logic [PULSE_W-1:0]   pulse_us;
    logic [OUT_CNT_W-1:0] samples;
    logic [OUT_CNT_W-1:0] timeouts;
    logic [OUT_CNT_W-1:0] errors;
  } res_item_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_P,
    S_DIVST_P,
    S_DIV_P,
    S_MUL_D,
    S_SAVE_D,
    S_EMIT
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic arm;
    logic rise;
    logic fall;
    logic expire;
    logic mul_pulse;
    logic mul_dist;
    logic div_start;
    logic pulse_save;
    logic dist_save;
    logic emit;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic armed;
    logic rise_seen;
    logic div_busy;
    logic pulse_ok;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/ultrasonic_echo_ranger.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: echo pulse to distance converter
// Turns timestamped echo events into pulse width, outcome and distance.
// ----------------------------------------------------------------------------
// Arm, rise and ignored events are handled in the idle state. A wait expiry
// while armed goes to the emit state, which loads its result once the output
// register is free, and the next beat can follow after that. A falling edge
// that ends a measurement runs, for an ok reading, one multiply by 1e6, a
// divide by the timer rate (two quotient bits a cycle), then one multiply by
// a fixed scaled reciprocal for the distance. A too-short or timeout reading
// skips the distance step; a pulse that overflows 32 bits skips the divide
// iterations and saturates. Input is stalled until the current event has
// been finished; a finished result waits in the output register while the
// next event beat is taken, and a result still stalled there holds a new
// one back. Config writes are accepted at any time but must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  uer_pkg::req_item_t            req_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output uer_pkg::res_item_t            res_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uer_pkg::RATE_W-1:0]    cfg_data
);

  uer_pkg::dp_cmd_t  cmd;
  uer_pkg::dp_stat_t stat;

  // config writes always taken
  assign cfg_ready = 1'b1;

  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_data.req_type),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  uer_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .stamp     (req_data.stamp),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

/* rtl/uer_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module uer_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [uer_pkg::PROD_W-1:0]  dividend,
  input  logic [uer_pkg::RATE_W-1:0]  divisor,
  output logic                        busy,
  output logic                        sat,
  output logic [uer_pkg::QUOT_W-1:0]  quot
);

  localparam int HI_W   = uer_pkg::PROD_W - uer_pkg::QUOT_W;
  localparam int CYCLES = uer_pkg::QUOT_W / 2;
  localparam int CNT_W  = $clog2(CYCLES);
  localparam int R_W    = uer_pkg::RATE_W;

  logic [R_W-1:0]   rem;
  logic [R_W-1:0]   dvs;
  logic [CNT_W-1:0] count;

  logic [HI_W-1:0] hi;
  logic            sat_now;
  logic [R_W:0]    r1, r2, m1, m2;
  logic            ge1, ge2;

  // overflow check: high part not below divisor means quotient >= 2^32
  assign hi      = dividend[uer_pkg::PROD_W-1:uer_pkg::QUOT_W];
  assign sat_now = (R_W'(hi) >= divisor);

  // two restoring steps
  always_comb begin
    r1  = {rem, quot[uer_pkg::QUOT_W-1]};
    ge1 = (r1 >= {1'b0, dvs});
    m1  = ge1 ? (r1 - {1'b0, dvs}) : r1;
    r2  = {m1[R_W-1:0], quot[uer_pkg::QUOT_W-2]};
    ge2 = (r2 >= {1'b0, dvs});
    m2  = ge2 ? (r2 - {1'b0, dvs}) : r2;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      sat   <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= !sat_now;
      sat   <= sat_now;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CNT_W'(CYCLES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= sat_now ? '0 : R_W'(hi);
      quot <= dividend[uer_pkg::QUOT_W-1:0];
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= m2[R_W-1:0];
      quot <= {quot[uer_pkg::QUOT_W-3:0], ge1, ge2};
    end
  end

endmodule

/* rtl/uer_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_dp: echo ranger datapath
// Measurement state, config registers, shared multiplier and divider,
// totals and the result register.
// ----------------------------------------------------------------------------
module uer_dp #(
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  uer_pkg::dp_cmd_t              cmd,
  output uer_pkg::dp_stat_t             stat,
  input  logic [uer_pkg::STAMP_W-1:0]   stamp,
  input  logic                          cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uer_pkg::RATE_W-1:0]    cfg_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output uer_pkg::res_item_t            res_data
);

  logic [uer_pkg::RATE_W-1:0]  timer_rate;
  logic [uer_pkg::LIMIT_W-1:0] echo_limit;
  logic                        armed;
  logic                        rise_seen;
  logic [uer_pkg::STAMP_W-1:0] rise_stamp;
  logic [uer_pkg::STAMP_W-1:0] ticks;
  logic [uer_pkg::PROD_W-1:0]  prod;
  logic [uer_pkg::PULSE_W-1:0] pulse;
  uer_pkg::status_t            status_r;
  logic [uer_pkg::DIST_W-1:0]  last_distance;
  logic [COUNT_BITS-1:0]       sample_total;
  logic [COUNT_BITS-1:0]       timeout_total;
  logic [COUNT_BITS-1:0]       error_total;

  logic [uer_pkg::STAMP_W-1:0] mul_a;
  logic [uer_pkg::MUL_B_W-1:0] mul_b;
  logic [uer_pkg::STAMP_W+uer_pkg::MUL_B_W-1:0] mul_full;
  logic                        div_busy;
  logic                        div_sat;
  logic [uer_pkg::QUOT_W-1:0]  div_quot;
  logic [uer_pkg::PULSE_W-1:0] pulse_next;
  uer_pkg::status_t            status_next;
  logic [COUNT_BITS-1:0]       sample_next;
  logic [COUNT_BITS-1:0]       timeout_next;
  logic [COUNT_BITS-1:0]       error_next;
  logic                        out_free;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_rate <= uer_pkg::RATE_RESET;
      echo_limit <= uer_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == uer_pkg::CFG_TIMER_RATE) begin
        timer_rate <= cfg_data;
      end
      if (cfg_index == uer_pkg::CFG_ECHO_LIMIT) begin
        echo_limit <= cfg_data[uer_pkg::LIMIT_W-1:0];
      end
    end
  end

  // arm and rise flags
  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      rise_seen <= 1'b0;
    end else if (cmd.arm) begin
      armed     <= 1'b1;
      rise_seen <= 1'b0;
    end else if (cmd.rise) begin
      rise_seen <= 1'b1;
    end else if (cmd.fall || cmd.expire) begin
      armed     <= 1'b0;
      rise_seen <= 1'b0;
    end
  end

  // stamps and tick difference
  always_ff @(posedge clk) begin
    if (cmd.rise) begin
      rise_stamp <= stamp;
    end
    if (cmd.fall) begin
      ticks <= stamp - rise_stamp;
    end
  end

  // shared multiplier: ticks * 1e6 or pulse * scaled reciprocal of 2000 / 343
  assign mul_a    = cmd.mul_dist ? pulse : ticks;
  assign mul_b    = cmd.mul_dist ? uer_pkg::DIST_RECIP : uer_pkg::US_PER_S;
  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_pulse || cmd.mul_dist) begin
      prod <= mul_full[uer_pkg::PROD_W-1:0];
    end
  end

  // divider by the timer rate
  uer_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (timer_rate),
    .busy     (div_busy),
    .sat      (div_sat),
    .quot     (div_quot)
  );

  // pulse width and outcome
  always_comb begin
    pulse_next = div_sat ? '1 : div_quot;
    if (pulse_next < uer_pkg::MIN_PULSE_US) begin
      status_next = uer_pkg::ST_SHORT;
    end else if (pulse_next > uer_pkg::PULSE_W'(echo_limit)) begin
      status_next = uer_pkg::ST_TIMEOUT;
    end else begin
      status_next = uer_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.expire) begin
      pulse    <= '0;
      status_r <= uer_pkg::ST_TIMEOUT;
    end else if (cmd.pulse_save) begin
      pulse    <= pulse_next;
      status_r <= status_next;
    end
  end

  // last good distance, upper part of pulse times the scaled reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance <= '0;
    end else if (cmd.dist_save) begin
      last_distance <=
        prod[uer_pkg::DIST_SHIFT+uer_pkg::DIST_W-1:uer_pkg::DIST_SHIFT];
    end
  end

  // wrapping totals
  always_comb begin
    sample_next  = sample_total + 1'b1;
    timeout_next = timeout_total;
    error_next   = error_total;
    if (status_r == uer_pkg::ST_TIMEOUT) begin
      timeout_next = timeout_total + 1'b1;
    end
    if (status_r == uer_pkg::ST_SHORT) begin
      error_next = error_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_total  <= '0;
      timeout_total <= '0;
      error_total   <= '0;
    end else if (cmd.emit) begin
      sample_total  <= sample_next;
      timeout_total <= timeout_next;
      error_total   <= error_next;
    end
  end

  // result register
  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_data.status        <= status_r;
      res_data.reading_valid <= (status_r == uer_pkg::ST_OK);
      res_data.range_mm      <= last_distance;
      res_data.pulse_us      <= pulse;
      res_data.samples       <= uer_pkg::OUT_CNT_W'(sample_next);
      res_data.timeouts      <= uer_pkg::OUT_CNT_W'(timeout_next);
      res_data.errors        <= uer_pkg::OUT_CNT_W'(error_next);
    end
  end

  // status to controller
  always_comb begin
    stat.armed     = armed;
    stat.rise_seen = rise_seen;
    stat.div_busy  = div_busy;
    stat.pulse_ok  = (status_next == uer_pkg::ST_OK);
    stat.out_free  = out_free;
  end

endmodule

/* rtl/uer_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_ctrl: echo ranger controller
// Takes event beats and sequences the multiply, divide and result steps.
// ----------------------------------------------------------------------------
module uer_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_type,
  output logic              req_stall,
  input  uer_pkg::dp_stat_t stat,
  output uer_pkg::dp_cmd_t  cmd
);

  uer_pkg::ctrl_state_t state;
  uer_pkg::ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uer_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != uer_pkg::S_IDLE);
    unique case (state)
      uer_pkg::S_IDLE: begin
        if (req_valid) begin
          unique case (req_type)
            uer_pkg::REQ_ARM: begin
              cmd.arm = 1'b1;
            end
            uer_pkg::REQ_RISE: begin
              cmd.rise = 1'b1;
            end
            uer_pkg::REQ_FALL: begin
              if (stat.armed && stat.rise_seen) begin
                cmd.fall   = 1'b1;
                state_next = uer_pkg::S_MUL_P;
              end
            end
            uer_pkg::REQ_EXPIRE: begin
              if (stat.armed) begin
                cmd.expire = 1'b1;
                state_next = uer_pkg::S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      uer_pkg::S_MUL_P: begin
        cmd.mul_pulse = 1'b1;
        state_next    = uer_pkg::S_DIVST_P;
      end
      uer_pkg::S_DIVST_P: begin
        cmd.div_start = 1'b1;
        state_next    = uer_pkg::S_DIV_P;
      end
      uer_pkg::S_DIV_P: begin
        if (!stat.div_busy) begin
          cmd.pulse_save = 1'b1;
          state_next     = stat.pulse_ok ? uer_pkg::S_MUL_D : uer_pkg::S_EMIT;
        end
      end
      uer_pkg::S_MUL_D: begin
        cmd.mul_dist = 1'b1;
        state_next   = uer_pkg::S_SAVE_D;
      end
      uer_pkg::S_SAVE_D: begin
        cmd.dist_save = 1'b1;
        state_next    = uer_pkg::S_EMIT;
      end
      uer_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = uer_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = uer_pkg::S_IDLE;
      end
    endcase
  end

endmodule
